// ----- rtl/core/advsr_pkg.sv -----
// Shared types, constants and helper functions for the voltmeter readout.
// Used by adc_voltage_seven_segment_readout; depends on nothing else.
`default_nettype none

package advsr_pkg;

  localparam int unsigned AdcBitsDefault = 10;
  localparam int unsigned FsWidth        = 24;
  localparam int unsigned ValWidth       = 24;
  localparam int unsigned BcdWidth       = 32;
  localparam int unsigned StepBits       = 8;
  localparam int unsigned NumDigits      = 4;
  localparam int unsigned SegWidth       = 7;
  localparam int unsigned AddrWidth      = 3;
  localparam int unsigned DataWidth      = 32;

  localparam logic [FsWidth-1:0] FsReset = 24'd5000;

  // Register byte addresses (bit 2 selects the word).
  localparam logic [0:0] RegFullScale = 1'b0;

  // Range thresholds on the value in thousandths.
  localparam logic [ValWidth-1:0] LimOver  = 24'd10000000;
  localparam logic [ValWidth-1:0] LimUnits = 24'd1000000;
  localparam logic [ValWidth-1:0] LimHund  = 24'd100000;
  localparam logic [ValWidth-1:0] LimTens  = 24'd10000;

  localparam logic [SegWidth-1:0] SegBlank = 7'h00;
  localparam logic [SegWidth-1:0] SegE     = 7'h79;

  typedef enum logic [2:0] {
    RNG_OVER,
    RNG_UNITS,
    RNG_HUND,
    RNG_TENS,
    RNG_MILLI
  } range_e;

  function automatic logic [SegWidth-1:0] seg_of_digit(input logic [3:0] digit);
    logic [SegWidth-1:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7C;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

  // Eight steps of shift-and-add-3 binary to BCD conversion.
  function automatic logic [BcdWidth-1:0] bcd_shift8(input logic [BcdWidth-1:0] bcd_in,
                                                      input logic [StepBits-1:0] bin);
    logic [BcdWidth-1:0] bcd;
    bcd = bcd_in;
    for (int s = 0; s < StepBits; s++) begin
      for (int d = 0; d < BcdWidth / 4; d++) begin
        if (bcd[4*d +: 4] >= 4'd5) begin
          bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
      end
      bcd = {bcd[BcdWidth-2:0], bin[StepBits-1-s]};
    end
    return bcd;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/adc_voltage_seven_segment_readout.sv -----
// Autoranging four-digit seven-segment voltmeter readout, top level.
// Depends on advsr_pkg for constants, the range type and conversion functions.
`default_nettype none

//  Channel   Direction  Handshake               Payload
//  input     in         in_valid_i/in_ready_o   adc_code_i
//  output    out        out_valid_o/out_ready_i digit_select_o, segments_o,
//                                               point_on_o, last_digit_o
//  config    in         APB psel/penable/pready full_scale_milli at address 0
//
// Five register stages: scale multiply, three BCD conversion stages of eight bits
// each, then a formatted digit holder. A sample's first digit appears once it reaches the
// digit holder. Each sample yields four output transactions, so the result port sets
// the sample rate; the earlier stages accept a new sample every cycle while they have
// room. A stall holds every stage that holds a sample in place; empty stages still fill.
// Reset clears the valid bits and the digit counter and loads full scale with 5000.

module adc_voltage_seven_segment_readout #(
  parameter int unsigned ADC_BITS = advsr_pkg::AdcBitsDefault
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [ADC_BITS-1:0]               adc_code_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [1:0]                        digit_select_o,
  output logic [advsr_pkg::SegWidth-1:0]    segments_o,
  output logic                              point_on_o,
  output logic                              last_digit_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [advsr_pkg::AddrWidth-1:0]   paddr,
  input  wire  [advsr_pkg::DataWidth-1:0]   pwdata,
  output logic [advsr_pkg::DataWidth-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned FsW  = advsr_pkg::FsWidth;
  localparam int unsigned VW   = advsr_pkg::ValWidth;
  localparam int unsigned BcdW = advsr_pkg::BcdWidth;
  localparam int unsigned SB   = advsr_pkg::StepBits;
  localparam int unsigned SegW = advsr_pkg::SegWidth;
  localparam int unsigned ND   = advsr_pkg::NumDigits;
  localparam int unsigned ProdW = ADC_BITS + FsW;

  // Configuration register.
  logic [FsW-1:0] fs_q;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= advsr_pkg::FsReset;
    end else if (cfg_wr && paddr[2] == advsr_pkg::RegFullScale) begin
      fs_q <= pwdata[FsW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == advsr_pkg::RegFullScale) begin
      prdata = {{(advsr_pkg::DataWidth - FsW){1'b0}}, fs_q};
    end
  end

  // Pipeline valid bits and load enables.
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  logic s1_en, s2_en, s3_en, s4_en, s5_en;
  logic [1:0] cnt_q;
  logic       out_fire;

  assign out_fire = out_valid_o & out_ready_i;
  assign s5_en = !s5_vld_q || (out_ready_i && cnt_q == 2'd3);
  assign s4_en = !s4_vld_q || s5_en;
  assign s3_en = !s3_vld_q || s4_en;
  assign s2_en = !s2_vld_q || s3_en;
  assign s1_en = !s1_vld_q || s2_en;
  assign in_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (s1_en) s1_vld_q <= in_valid_i;
      if (s2_en) s2_vld_q <= s1_vld_q;
      if (s3_en) s3_vld_q <= s2_vld_q;
      if (s4_en) s4_vld_q <= s3_vld_q;
      if (s5_en) s5_vld_q <= s4_vld_q;
      if (out_fire) cnt_q <= cnt_q + 2'd1;
    end
  end

  // Stage 1: scale to thousandths.
  logic [ProdW-1:0] prod;
  logic [VW-1:0]    s1_val_d, s1_val_q;

  assign prod     = {{FsW{1'b0}}, adc_code_i} * {{ADC_BITS{1'b0}}, fs_q};
  assign s1_val_d = prod[ADC_BITS +: VW];

  // Stage 2: pick the range and convert the top eight bits.
  advsr_pkg::range_e s2_rng_d, s2_rng_q, s3_rng_q, s4_rng_q;
  logic [BcdW-1:0]   s2_bcd_q, s3_bcd_q, s4_bcd_q;
  logic [2*SB-1:0]   s2_rest_q;
  logic [SB-1:0]     s3_rest_q;

  always_comb begin
    if (s1_val_q >= advsr_pkg::LimOver) begin
      s2_rng_d = advsr_pkg::RNG_OVER;
    end else if (s1_val_q >= advsr_pkg::LimUnits) begin
      s2_rng_d = advsr_pkg::RNG_UNITS;
    end else if (s1_val_q >= advsr_pkg::LimHund) begin
      s2_rng_d = advsr_pkg::RNG_HUND;
    end else if (s1_val_q >= advsr_pkg::LimTens) begin
      s2_rng_d = advsr_pkg::RNG_TENS;
    end else begin
      s2_rng_d = advsr_pkg::RNG_MILLI;
    end
  end

  // Stage 5: select the four digits of the range and encode them.
  logic [SegW-1:0] seg_d [ND];
  logic [SegW-1:0] seg_q [ND];
  logic [ND-1:0]   pt_d, pt_q;
  logic [4*ND-1:0] win;

  always_comb begin
    case (s4_rng_q)
      advsr_pkg::RNG_UNITS: begin
        win  = s4_bcd_q[27:12];
        pt_d = 4'b0000;
      end
      advsr_pkg::RNG_HUND: begin
        win  = s4_bcd_q[23:8];
        pt_d = 4'b0100;
      end
      advsr_pkg::RNG_TENS: begin
        win  = s4_bcd_q[19:4];
        pt_d = 4'b0010;
      end
      default: begin
        win  = s4_bcd_q[15:0];
        pt_d = 4'b0001;
      end
    endcase
    for (int k = 0; k < ND; k++) begin
      seg_d[k] = advsr_pkg::seg_of_digit(win[4*(ND-1-k) +: 4]);
    end
    if (s4_rng_q == advsr_pkg::RNG_OVER) begin
      pt_d = '0;
      for (int k = 0; k < ND - 1; k++) begin
        seg_d[k] = advsr_pkg::SegBlank;
      end
      seg_d[ND-1] = advsr_pkg::SegE;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_val_q <= s1_val_d;
    end
    if (s2_en) begin
      s2_rng_q  <= s2_rng_d;
      s2_bcd_q  <= advsr_pkg::bcd_shift8('0, s1_val_q[VW-1 -: SB]);
      s2_rest_q <= s1_val_q[2*SB-1:0];
    end
    if (s3_en) begin
      s3_rng_q  <= s2_rng_q;
      s3_bcd_q  <= advsr_pkg::bcd_shift8(s2_bcd_q, s2_rest_q[2*SB-1:SB]);
      s3_rest_q <= s2_rest_q[SB-1:0];
    end
    if (s4_en) begin
      s4_rng_q <= s3_rng_q;
      s4_bcd_q <= advsr_pkg::bcd_shift8(s3_bcd_q, s3_rest_q);
    end
    if (s5_en) begin
      seg_q <= seg_d;
      pt_q  <= pt_d;
    end
  end

  // The holder walks its four digits, most significant first.
  assign out_valid_o    = s5_vld_q;
  assign digit_select_o = cnt_q;
  assign segments_o     = seg_q[cnt_q];
  assign point_on_o     = pt_q[cnt_q];
  assign last_digit_o   = (cnt_q == 2'd3);

  // The digit counter only moves while a sample is being shown.
  a_cnt_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> s5_vld_q)
    else $error("digit counter left zero with no sample held");

  // A sample stays in the holder until its fourth digit is taken.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_digit_o) |=> out_valid_o)
    else $error("sample dropped before its last digit");

  // After the last digit the next sample starts at the first position.
  a_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last_digit_o) |=> (cnt_q == 2'd0))
    else $error("digit counter did not wrap after the last digit");

  // Back pressure at the input only when the first stage holds a sample.
  a_inrdy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_vld_q)
    else $error("input stalled with an empty first stage");

endmodule

`default_nettype wire
